>>> rtl/core/edge_count_hash_table_macros.svh
// Assertion helpers for the edge count hash table.
`ifndef EDGE_COUNT_HASH_TABLE_MACROS_SVH
`define EDGE_COUNT_HASH_TABLE_MACROS_SVH
// Assert an implication on every clock edge outside reset.
`define ECHT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Assert that the consequent holds in the cycle after the antecedent.
`define ECHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/core/echt_pkg.sv
package echt_pkg;
  localparam int unsigned Buckets    = 256;
  localparam int unsigned Entries    = 1024;
  localparam int unsigned IdBits     = 16;
  localparam int unsigned HashShift  = 8;
  localparam int unsigned BucketW    = $clog2(Buckets);
  localparam int unsigned NodeW      = $clog2(Entries);
  localparam int unsigned NodeCntW   = NodeW + 1;
  localparam int unsigned DivW       = BucketW + 1;
  localparam int unsigned HashW      = IdBits + HashShift;
  localparam int unsigned KeyW       = 2 * IdBits + 2;
  localparam int unsigned CountW     = 32;
  localparam int unsigned TotW       = 11;

  typedef enum logic [0:0] {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_HEAD,
    ST_NODE,
    ST_CHECK,
    ST_DONE
  } state_e;

  // Remainder unit command and status.
  typedef struct packed {
    logic             start;
    logic [HashW-1:0] dividend;
    logic [DivW-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic               done;
    logic [BucketW-1:0] rem;
  } mod_rsp_t;
endpackage

>>> rtl/core/echt_mod.sv
// Restoring remainder, one dividend bit per cycle.
module echt_mod (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  echt_pkg::mod_req_t req_i,
  output echt_pkg::mod_rsp_t rsp_o
);
  import echt_pkg::*;
  localparam int unsigned StepW = $clog2(HashW + 1);

  logic [HashW-1:0] div_q, div_d;
  logic [DivW-1:0]  rem_q, rem_d;
  logic [DivW-1:0]  dsr_q, dsr_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DivW:0]    trial;

  always_comb begin
    div_d = div_q; rem_d = rem_q; dsr_d = dsr_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q, div_q[HashW-1]};
    if (req_i.start) begin
      div_d = req_i.dividend; dsr_d = req_i.divisor; rem_d = '0;
      cnt_d = StepW'(HashW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) rem_d = DivW'(trial - {1'b0, dsr_q});
      else rem_d = DivW'(trial);
      div_d = {div_q[HashW-2:0], 1'b0};
      cnt_d = cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d; rem_q <= rem_d; dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[BucketW-1:0];
endmodule

>>> rtl/core/echt_heads.sv
// Bucket head memory with per-bucket valid bits.
module echt_heads (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [echt_pkg::BucketW-1:0] raddr_i,
  output logic                         rvalid_o,
  output logic [echt_pkg::NodeW-1:0]   rdata_o,
  input  logic                         we_i,
  input  logic [echt_pkg::BucketW-1:0] waddr_i,
  input  logic [echt_pkg::NodeW-1:0]   wdata_i
);
  import echt_pkg::*;
  logic [NodeW-1:0]   mem [Buckets];
  logic [Buckets-1:0] vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0; rvalid_o <= 1'b0;
    end else begin
      rvalid_o <= vld_q[raddr_i];
      if (we_i) vld_q[waddr_i] <= 1'b1;
    end
  end
endmodule

>>> rtl/core/echt_nodes.sv
// Node store: key, hit count, link and link valid per entry.
module echt_nodes (
  input  logic                        clk_i,
  input  logic [echt_pkg::NodeW-1:0]  raddr_i,
  output logic [echt_pkg::KeyW-1:0]   rkey_o,
  output logic [echt_pkg::CountW-1:0] rcount_o,
  output logic [echt_pkg::NodeW-1:0]  rlink_o,
  output logic                        rlvld_o,
  input  logic                        we_i,
  input  logic [echt_pkg::NodeW-1:0]  waddr_i,
  input  logic [echt_pkg::KeyW-1:0]   wkey_i,
  input  logic [echt_pkg::CountW-1:0] wcount_i,
  input  logic [echt_pkg::NodeW-1:0]  wlink_i,
  input  logic                        wlvld_i
);
  import echt_pkg::*;
  localparam int unsigned W = KeyW + CountW + NodeW + 1;
  logic [W-1:0] mem [Entries];
  logic [W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= {wkey_i, wcount_i, wlink_i, wlvld_i};
    rd_q <= mem[raddr_i];
  end

  assign {rkey_o, rcount_o, rlink_o, rlvld_o} = rd_q;
endmodule

>>> rtl/core/edge_count_hash_table.sv
// Chained hash table of edges keyed by (src, dest, kind). One operation at a
// time: start is taken when busy is low, and one result beat appears on
// done_o for exactly one cycle; the receiver cannot stall, so capture it.
// The bucket index comes from a bit-serial shift and subtract remainder unit,
// which then hands the remainder over. An insert then reads the head and
// writes node and head. A lookup that hits an empty bucket ends at the head
// read as well; otherwise each chain node visited adds a node memory read and
// a compare, with count write-back on a hit. busy drops with the result beat,
// so the next start can be taken at the edge that ends that beat. Bucket heads
// carry valid bits cleared at reset; no clearing pass. Write bucket_count only
// while busy is low.
module edge_count_hash_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [8:0]                  cfg_wdata_i,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op_i,
  input  logic [15:0]                 src_id_i,
  input  logic [15:0]                 dest_id_i,
  input  logic [1:0]                  edge_kind_i,
  output logic                        done_o,
  output logic                        found_o,
  output logic [31:0]                 hit_count_o,
  output logic                        store_full_o,
  output logic [10:0]                 total_entries_o,
  output logic [10:0]                 read_edges_o,
  output logic [10:0]                 write_edges_o,
  output logic [10:0]                 call_edges_o,
  output logic [10:0]                 return_edges_o
);
  import echt_pkg::*;
  `include "edge_count_hash_table_macros.svh"

  localparam logic [CountW-1:0] CountMax = '1;

  state_e             st_q, st_d;
  logic [DivW-1:0]    bcnt_q;
  logic               op_q;
  logic [KeyW-1:0]    key_q;
  logic [1:0]         kind_q;
  logic [BucketW-1:0] bkt_q, bkt_d;
  logic [NodeW-1:0]   cur_q, cur_d;
  logic [NodeCntW-1:0] free_q;
  logic [TotW-1:0]    tot_q [4];
  logic [NodeCntW-1:0] steps_q, steps_d;

  mod_req_t mreq;
  mod_rsp_t mrsp;
  logic               h_rvld;
  logic [NodeW-1:0]   h_rdata;
  logic               h_we;
  logic [KeyW-1:0]    n_key;
  logic [CountW-1:0]  n_cnt;
  logic [NodeW-1:0]   n_link;
  logic               n_lvld;
  logic               n_we;
  logic [CountW-1:0]  n_wcnt;
  logic [KeyW-1:0]    n_wkey;
  logic [NodeW-1:0]   n_waddr, n_wlink;
  logic               n_wlvld;
  logic               full;
  logic               done_d, found_d, sfull_d;
  logic [CountW-1:0]  hit_d;
  logic [15:0]        src_m, dst_m;

  // Keep only the id bits in use.
  assign src_m = 16'(src_id_i[IdBits-1:0]);
  assign dst_m = 16'(dest_id_i[IdBits-1:0]);
  assign full = (free_q >= NodeCntW'(Entries));
  assign busy = (st_q != ST_IDLE);

  // Clamp the bucket count into 1..Buckets on write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q <= DivW'(Buckets);
    end else if (cfg_we_i) begin
      if (cfg_wdata_i == 9'd0) bcnt_q <= DivW'(1);
      else if ({23'd0, cfg_wdata_i} > 32'(Buckets)) bcnt_q <= DivW'(Buckets);
      else bcnt_q <= DivW'(cfg_wdata_i);
    end
  end

  always_comb begin
    mreq.start    = start && !busy;
    mreq.dividend = (HashW'(src_m) << HashShift) ^ HashW'(dst_m) ^ HashW'(edge_kind_i);
    mreq.divisor  = bcnt_q;
  end

  echt_mod u_mod (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));

  echt_heads u_heads (
    .clk_i, .rst_ni,
    .raddr_i(bkt_d), .rvalid_o(h_rvld), .rdata_o(h_rdata),
    .we_i(h_we), .waddr_i(bkt_q), .wdata_i(free_q[NodeW-1:0])
  );

  echt_nodes u_nodes (
    .clk_i, .raddr_i(cur_d),
    .rkey_o(n_key), .rcount_o(n_cnt), .rlink_o(n_link), .rlvld_o(n_lvld),
    .we_i(n_we), .waddr_i(n_waddr), .wkey_i(n_wkey), .wcount_i(n_wcnt),
    .wlink_i(n_wlink), .wlvld_i(n_wlvld)
  );

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:  if (start) st_d = ST_MOD;
      ST_MOD:   if (mrsp.done) st_d = ST_HEAD;
      ST_HEAD: begin
        if (op_q == OP_INSERT) st_d = ST_IDLE;
        else if (!h_rvld) st_d = ST_IDLE;
        else st_d = ST_NODE;
      end
      ST_NODE:  st_d = ST_CHECK;
      ST_CHECK: begin
        if (n_key == key_q) st_d = ST_IDLE;
        else if (!n_lvld || steps_q + NodeCntW'(1) >= NodeCntW'(Entries)) st_d = ST_IDLE;
        else st_d = ST_NODE;
      end
      default:  st_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath controls.
  always_comb begin
    bkt_d = bkt_q; cur_d = cur_q; steps_d = steps_q;
    h_we = 1'b0; n_we = 1'b0;
    n_waddr = cur_q; n_wkey = key_q; n_wcnt = n_cnt; n_wlink = n_link; n_wlvld = n_lvld;
    done_d = 1'b0; found_d = 1'b0; hit_d = '0; sfull_d = 1'b0;
    unique case (st_q)
      ST_MOD: if (mrsp.done) bkt_d = mrsp.rem;
      ST_HEAD: begin
        if (op_q == OP_INSERT) begin
          done_d = 1'b1;
          if (full) sfull_d = 1'b1;
          else begin
            // Link the new node in front of the current head.
            h_we = 1'b1; n_we = 1'b1;
            n_waddr = free_q[NodeW-1:0]; n_wkey = key_q; n_wcnt = CountW'(1);
            n_wlink = h_rdata; n_wlvld = h_rvld;
          end
        end else if (!h_rvld) begin
          done_d = 1'b1;
        end else begin
          cur_d = h_rdata; steps_d = '0;
        end
      end
      ST_CHECK: begin
        if (n_key == key_q) begin
          // Count the hit and write it back.
          done_d = 1'b1; found_d = 1'b1; n_we = 1'b1;
          n_wcnt = (n_cnt == CountMax) ? n_cnt : n_cnt + CountW'(1);
          hit_d = n_wcnt;
        end else if (!n_lvld || steps_q + NodeCntW'(1) >= NodeCntW'(Entries)) begin
          done_d = 1'b1;
        end else begin
          cur_d = n_link; steps_d = steps_q + NodeCntW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; free_q <= '0; done_o <= 1'b0;
      for (int i = 0; i < 4; i++) tot_q[i] <= '0;
    end else begin
      st_q <= st_d; done_o <= done_d;
      if (h_we) begin
        free_q <= free_q + NodeCntW'(1);
        tot_q[kind_q] <= tot_q[kind_q] + TotW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q <= op_i; key_q <= {src_m, dst_m, edge_kind_i}; kind_q <= edge_kind_i;
    end
    bkt_q <= bkt_d; cur_q <= cur_d; steps_q <= steps_d;
    found_o <= found_d; hit_count_o <= hit_d; store_full_o <= sfull_d;
  end

  assign total_entries_o = TotW'(free_q);
  assign read_edges_o    = tot_q[0];
  assign write_edges_o   = tot_q[1];
  assign call_edges_o    = tot_q[2];
  assign return_edges_o  = tot_q[3];

  `ECHT_ASSERT_NEXT(a_done_idle, done_d, st_q == ST_IDLE, "result without return to idle")
  `ECHT_ASSERT_IMPL(a_free_bound, 1'b1, free_q <= NodeCntW'(Entries), "free pointer overrun")
  `ECHT_ASSERT_IMPL(a_full_insert, sfull_d, op_q == OP_INSERT && full, "bad store full flag")
  `ECHT_ASSERT_IMPL(a_one_write, h_we, n_we && !found_d, "head write without node write")
endmodule

>>> sim/edge_count_hash_table_test.sv
module edge_count_hash_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import echt_pkg::*;

  // One request beat: operation and edge key.
  typedef struct {
    op_e         op;
    logic [15:0] src;
    logic [15:0] dest;
    logic [1:0]  kind;
  } edge_req_t;

  // One result beat as the table reports it.
  typedef struct {
    logic        found;
    logic [31:0] hits;
    logic        full;
    logic [10:0] total;
    logic [10:0] per_kind [4];
  } edge_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_wdata_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic        op_i = 1'b0;
  logic [15:0] src_id_i = '0;
  logic [15:0] dest_id_i = '0;
  logic [1:0]  edge_kind_i = '0;
  logic        done_o, found_o, store_full_o;
  logic [31:0] hit_count_o;
  logic [10:0] total_entries_o, read_edges_o, write_edges_o, call_edges_o, return_edges_o;

  edge_count_hash_table dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .start, .busy,
    .op_i, .src_id_i, .dest_id_i, .edge_kind_i,
    .done_o, .found_o, .hit_count_o, .store_full_o, .total_entries_o,
    .read_edges_o, .write_edges_o, .call_edges_o, .return_edges_o
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the table: node store, bucket heads, counters, divisor.
  logic [15:0] node_src  [Entries];
  logic [15:0] node_dest [Entries];
  logic [1:0]  node_kind [Entries];
  logic [31:0] node_hits [Entries];
  int unsigned node_link [Entries];
  bit          node_linked [Entries];
  int unsigned head_node [Buckets];
  bit          head_used [Buckets];
  int unsigned nodes_used = 0;
  logic [10:0] kind_total [4] = '{default: '0};
  int unsigned divisor = Buckets;

  edge_req_t   pending_beats [$];
  edge_rsp_t   expected_beats [$];
  edge_req_t   known_keys [$];   // keys inserted so far, to aim lookups at
  int unsigned mismatches = 0;
  int unsigned beats_in = 0, beats_out = 0, hits_seen = 0, drops_seen = 0;
  int unsigned planned_inserts = 0;
  bit          beat_taken = 1'b0;
  bit          calm_tail = 1'b0;

  // Bucket of a key under the divisor in force.
  function automatic int unsigned bucket_of(edge_req_t r);
    logic [23:0] h;
    h = {r.src, 8'h00} ^ {8'h00, r.dest} ^ {22'h0, r.kind};
    return int'(h) % divisor;
  endfunction

  // Field by field compare of two result beats.
  function automatic bit rsp_equal(edge_rsp_t a, edge_rsp_t b);
    bit same;
    same = (a.found === b.found) && (a.hits === b.hits) && (a.full === b.full) &&
           (a.total === b.total);
    for (int k = 0; k < 4; k++) same = same && (a.per_kind[k] === b.per_kind[k]);
    return same;
  endfunction

  // Apply one request to the shadow table and return the beat it must give.
  function automatic edge_rsp_t table_step(edge_req_t r);
    edge_rsp_t   rsp;
    int unsigned b, cur, steps;
    bit          live;
    b = bucket_of(r);
    rsp.found = 1'b0;
    rsp.hits = '0;
    rsp.full = 1'b0;
    if (r.op == OP_LOOKUP) begin
      live = head_used[b];
      cur = head_node[b];
      steps = 0;
      while (live && steps < Entries) begin
        if (node_src[cur] == r.src && node_dest[cur] == r.dest && node_kind[cur] == r.kind) begin
          if (node_hits[cur] != 32'hFFFF_FFFF) node_hits[cur]++;
          rsp.found = 1'b1;
          rsp.hits = node_hits[cur];
          break;
        end
        live = node_linked[cur];
        cur = node_link[cur];
        steps++;
      end
    end else if (nodes_used >= Entries) begin
      rsp.full = 1'b1;
    end else begin
      node_src[nodes_used] = r.src;
      node_dest[nodes_used] = r.dest;
      node_kind[nodes_used] = r.kind;
      node_hits[nodes_used] = 32'd1;
      node_link[nodes_used] = head_node[b];
      node_linked[nodes_used] = head_used[b];
      head_node[b] = nodes_used;
      head_used[b] = 1'b1;
      nodes_used++;
      kind_total[r.kind]++;
    end
    rsp.total = 11'(nodes_used);
    rsp.per_kind = kind_total;
    return rsp;
  endfunction

  // Accept side: predict on every taken request, check every result beat.
  always @(posedge clk_i) begin
    edge_req_t r;
    edge_rsp_t got, want;
    if (start && !busy) begin
      r.op = op_e'(op_i);
      r.src = src_id_i;
      r.dest = dest_id_i;
      r.kind = edge_kind_i;
      expected_beats.push_back(table_step(r));
      beats_in++;
      beat_taken = 1'b1;
    end
    if (done_o) begin
      beats_out++;
      got.found = found_o;
      got.hits = hit_count_o;
      got.full = store_full_o;
      got.total = total_entries_o;
      got.per_kind = '{read_edges_o, write_edges_o, call_edges_o, return_edges_o};
      if (found_o) hits_seen++;
      if (store_full_o) drops_seen++;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("[%0t] result beat with nothing expected", $realtime);
      end else begin
        want = expected_beats.pop_front();
        if (!rsp_equal(got, want)) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] exp found=%0b hits=%0d full=%0b tot=%0d k=%0d/%0d/%0d/%0d | got found=%0b hits=%0d full=%0b tot=%0d k=%0d/%0d/%0d/%0d",
                     $realtime, want.found, want.hits, want.full, want.total,
                     want.per_kind[0], want.per_kind[1], want.per_kind[2], want.per_kind[3],
                     got.found, got.hits, got.full, got.total,
                     got.per_kind[0], got.per_kind[1], got.per_kind[2], got.per_kind[3]);
        end
      end
    end
  end

  // Driver: hold a request until it is taken, then advance or idle a burst.
  int unsigned idle_left = 0;
  always @(negedge clk_i) begin
    edge_req_t r;
    logic      next_start;
    next_start = start;
    if (start && !beat_taken) begin
      next_start = 1'b1;
    end else if (idle_left > 0) begin
      idle_left--;
      next_start = 1'b0;
    end else if (pending_beats.size() > 0) begin
      r = pending_beats.pop_front();
      op_i <= r.op;
      src_id_i <= r.src;
      dest_id_i <= r.dest;
      edge_kind_i <= r.kind;
      next_start = 1'b1;
      if (!calm_tail && $urandom_range(0, 5) == 0) idle_left = $urandom_range(1, 11);
    end else begin
      next_start = 1'b0;
    end
    beat_taken = 1'b0;
    start <= next_start;
  end

  function automatic edge_req_t make_req(op_e op, logic [15:0] s, logic [15:0] d, logic [1:0] k);
    edge_req_t r;
    r.op = op;
    r.src = s;
    r.dest = d;
    r.kind = k;
    return r;
  endfunction

  // Queue one request and remember inserted keys for later lookups.
  task automatic queue_req(edge_req_t r);
    if (r.op == OP_INSERT) begin
      known_keys.push_back(r);
      planned_inserts++;
    end
    pending_beats.push_back(r);
  endtask

  // Random mix: mostly inserts until twenty more than the store holds are planned,
  // lookups aimed at known keys most of the time, the rest random keys that usually miss.
  task automatic queue_random(int unsigned n);
    edge_req_t r;
    int unsigned pick;
    repeat (n) begin
      r = make_req(OP_LOOKUP, 16'($urandom), 16'($urandom), 2'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < ((planned_inserts < Entries + 20) ? 70 : 15)) begin
        r.op = OP_INSERT;
        // Occasionally take src and dest from known keys, each drawn on its own, to build duplicates.
        if (known_keys.size() > 0 && $urandom_range(0, 9) == 0)
          r = make_req(OP_INSERT, known_keys[$urandom_range(0, known_keys.size() - 1)].src,
                       known_keys[$urandom_range(0, known_keys.size() - 1)].dest, r.kind);
      end else if (known_keys.size() > 0 && $urandom_range(0, 9) < 7) begin
        r = known_keys[$urandom_range(0, known_keys.size() - 1)];
        r.op = OP_LOOKUP;
      end
      queue_req(r);
    end
  endtask

  // Hold until nothing is queued, driven or in flight, checked after each edge.
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_beats.size() != 0 || expected_beats.size() != 0 || start || busy);
  endtask

  // Wait until the table has drained, let any tail activity settle, then
  // write the divisor.
  task automatic drain_and_set(logic [8:0] value);
    wait_drained();
    repeat (40) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (value == 0) divisor = 1;
    else if (value > Buckets) divisor = Buckets;
    else divisor = value;
  endtask

  initial begin
    for (int i = 0; i < Buckets; i++) begin
      head_used[i] = 1'b0;
      head_node[i] = 0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, every kind, misses, duplicates.
    queue_req(make_req(OP_LOOKUP, 16'h0000, 16'h0000, 2'd0));
    queue_req(make_req(OP_INSERT, 16'h0000, 16'h0000, 2'd0));
    queue_req(make_req(OP_INSERT, 16'hFFFF, 16'hFFFF, 2'd3));
    queue_req(make_req(OP_INSERT, 16'hFFFF, 16'h0000, 2'd1));
    queue_req(make_req(OP_INSERT, 16'h0000, 16'hFFFF, 2'd2));
    queue_req(make_req(OP_LOOKUP, 16'h0000, 16'h0000, 2'd0));
    queue_req(make_req(OP_LOOKUP, 16'h0000, 16'h0000, 2'd0));
    queue_req(make_req(OP_LOOKUP, 16'hFFFF, 16'hFFFF, 2'd3));
    queue_req(make_req(OP_LOOKUP, 16'hFFFF, 16'h0000, 2'd1));
    queue_req(make_req(OP_LOOKUP, 16'h0000, 16'hFFFF, 2'd2));
    queue_req(make_req(OP_LOOKUP, 16'h0000, 16'h0000, 2'd1));
    queue_req(make_req(OP_INSERT, 16'h0000, 16'h0000, 2'd0));
    queue_req(make_req(OP_LOOKUP, 16'h0000, 16'h0000, 2'd0));
    queue_req(make_req(OP_LOOKUP, 16'h0000, 16'h0000, 2'd0));
    // Same bucket under 256 buckets: src 1 dest 0 collides with src 0 dest 256.
    queue_req(make_req(OP_INSERT, 16'h0001, 16'h0000, 2'd2));
    queue_req(make_req(OP_INSERT, 16'h0000, 16'h0100, 2'd2));
    queue_req(make_req(OP_LOOKUP, 16'h0001, 16'h0000, 2'd2));
    queue_req(make_req(OP_LOOKUP, 16'h0000, 16'h0100, 2'd2));
    queue_random(60);

    // Walk the divisor through its extremes and odd values; older entries
    // stay in their original chains.
    drain_and_set(9'd1);
    queue_random(60);
    drain_and_set(9'd0);
    queue_random(40);
    drain_and_set(9'h1FF);
    queue_random(500);
    drain_and_set(9'd300);
    queue_random(300);
    drain_and_set(9'd7);
    queue_random(150);
    drain_and_set(9'd256);
    queue_random(200);
    wait (pending_beats.size() < 150);
    calm_tail = 1'b1;
    queue_random(200);

    wait_drained();
    repeat (64) @(posedge clk_i);
    $display("Ran %0d requests, %0d result beats: %0d lookup hits, %0d dropped inserts,",
             beats_in, beats_out, hits_seen, drops_seen);
    $display("  divisors 256, 1, 0, 511, 300, 7; %0d mismatches", mismatches);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("Timed out with %0d result beats outstanding", expected_beats.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/echt_pkg.sv
rtl/core/echt_mod.sv
rtl/core/echt_heads.sv
rtl/core/echt_nodes.sv
rtl/core/edge_count_hash_table.sv
sim/edge_count_hash_table_test.sv
